/* rtl/core/klr_pkg.sv */
`default_nettype none

package klr_pkg;

    // Key table size and the widths that follow from it.
    localparam int KEY_COUNT = 768;
    localparam int KEY_AW    = $clog2(KEY_COUNT);

    // Field widths of the channels and the configuration port.
    localparam int CODE_W   = 10;
    localparam int PS_W     = 2;
    localparam int TIME_W   = 32;
    localparam int ACT_W    = 3;
    localparam int HELD_W   = 10;
    localparam int CFG_W    = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;
    localparam int NRES     = 5;
    localparam int NRES_W   = 3;

    // Configuration register indexes and reset values.
    localparam logic REG_LONG_HOLD = 1'b0;
    localparam logic REG_MAX_HOLD  = 1'b1;
    localparam logic [CFG_W-1:0] LONG_HOLD_RST = 16'd700;
    localparam logic [CFG_W-1:0] MAX_HOLD_RST  = 16'd5000;

    // Press states.
    localparam logic [PS_W-1:0] PS_RELEASE = 2'd0;
    localparam logic [PS_W-1:0] PS_PRESS   = 2'd1;

    // Result actions.
    localparam logic [ACT_W-1:0] ACT_HOST       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_HOME_SHORT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_HOME_LONG  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LEAVE      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REINJECT   = 3'd4;

    // Scan codes with a special meaning.
    localparam logic [CODE_W-1:0] KEY_HOME     = 10'd580;
    localparam logic [CODE_W-1:0] KEY_BACK     = 10'd158;
    localparam logic [CODE_W-1:0] KEY_VOL_DN   = 10'd114;
    localparam logic [CODE_W-1:0] KEY_VOL_UP   = 10'd115;
    localparam logic [CODE_W-1:0] KEY_PWR      = 10'd116;
    localparam logic [CODE_W-1:0] KEY_SYM_A    = 10'd222;
    localparam logic [CODE_W-1:0] KEY_SYM_B    = 10'd253;
    localparam logic [CODE_W-1:0] KEY_LCTRL    = 10'd29;
    localparam logic [CODE_W-1:0] KEY_LSHIFT   = 10'd42;
    localparam logic [CODE_W-1:0] KEY_RSHIFT   = 10'd54;
    localparam logic [CODE_W-1:0] KEY_LALT     = 10'd56;
    localparam logic [CODE_W-1:0] KEY_RCTRL    = 10'd97;
    localparam logic [CODE_W-1:0] KEY_FREE_ALT = 10'd100;
    localparam logic [CODE_W-1:0] KEY_LMETA    = 10'd125;
    localparam logic [CODE_W-1:0] KEY_RMETA    = 10'd126;
    localparam logic [CODE_W-1:0] KEY_FN_A     = 10'd183;
    localparam logic [CODE_W-1:0] KEY_FN_B     = 10'd251;

    // Keycodes sent with a reinject action.
    localparam logic [CODE_W-1:0] AKEY_VOL_UP = 10'd24;
    localparam logic [CODE_W-1:0] AKEY_VOL_DN = 10'd25;
    localparam logic [CODE_W-1:0] AKEY_PWR    = 10'd26;

    // One entry of the per-key memory.
    typedef struct packed {
        logic              kd;
        logic              added;
        logic [CODE_W-1:0] sent;
    } t_entry;

    // Write port of the per-key memory.
    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
        t_entry            data;
    } t_mem_wr;

    // One result transaction.
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CODE_W-1:0] out_code;
        logic              is_down;
        logic [HELD_W-1:0] held_count;
        logic              last;
    } t_result;

    // Symbol layer lookup result.
    typedef struct packed {
        logic              hit;
        logic              shift;
        logic [CODE_W-1:0] code;
    } t_layer;

    // Symbol layer glyph table, already in host codes.
    function automatic t_layer layer_map(input logic [CODE_W-1:0] code);
        t_layer r;
        r = '{hit: 1'b1, shift: 1'b0, code: '0};
        unique case (code)
            10'd16: r.code = 10'd11;
            10'd17: r.code = 10'd2;
            10'd18: r.code = 10'd3;
            10'd19: r.code = 10'd4;
            10'd20: begin r.shift = 1'b1; r.code = 10'd10; end
            10'd21: begin r.shift = 1'b1; r.code = 10'd11; end
            10'd22: begin r.shift = 1'b1; r.code = 10'd12; end
            10'd23: r.code = 10'd12;
            10'd24: r.code = 10'd53;
            10'd25: begin r.shift = 1'b1; r.code = 10'd39; end
            10'd30: begin r.shift = 1'b1; r.code = 10'd3; end
            10'd31: r.code = 10'd5;
            10'd32: r.code = 10'd6;
            10'd33: r.code = 10'd7;
            10'd34: begin r.shift = 1'b1; r.code = 10'd9; end
            10'd35: begin r.shift = 1'b1; r.code = 10'd4; end
            10'd36: begin r.shift = 1'b1; r.code = 10'd13; end
            10'd37: begin r.shift = 1'b1; r.code = 10'd40; end
            10'd38: r.code = 10'd40;
            10'd44: begin r.shift = 1'b1; r.code = 10'd2; end
            10'd45: r.code = 10'd8;
            10'd46: r.code = 10'd9;
            10'd47: r.code = 10'd10;
            10'd48: r.code = 10'd52;
            10'd49: r.code = 10'd51;
            10'd50: begin r.shift = 1'b1; r.code = 10'd53; end
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // Renames free Alt and the Fn keys; other codes pass unchanged.
    function automatic logic [CODE_W-1:0] host_code(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] r;
        unique case (code)
            KEY_FREE_ALT:     r = KEY_LALT;
            KEY_FN_A, KEY_FN_B: r = KEY_LCTRL;
            default:          r = code;
        endcase
        return r;
    endfunction

    // Modifier keys do not count as held keys.
    function automatic logic is_modifier(input logic [CODE_W-1:0] code);
        logic r;
        unique case (code)
            KEY_LCTRL, KEY_LSHIFT, KEY_RSHIFT, KEY_LALT, KEY_RCTRL, KEY_FREE_ALT,
            KEY_LMETA, KEY_RMETA, KEY_FN_A, KEY_SYM_A, KEY_FN_B, KEY_SYM_B: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/klr_in_if.sv */
`default_nettype none

interface klr_in_if;
    import klr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] key_code;
    logic [PS_W-1:0]   press_state;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, key_code, press_state, time_ms, input ready);
    modport sink (input valid, key_code, press_state, time_ms, output ready);
endinterface

`default_nettype wire

/* rtl/core/klr_out_if.sv */
`default_nettype none

interface klr_out_if;
    import klr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [CODE_W-1:0] out_code;
    logic              is_down;
    logic [HELD_W-1:0] held_count;
    logic              last;

    modport source (output valid, action, out_code, is_down, held_count, last,
                    input ready);
    modport sink (input valid, action, out_code, is_down, held_count, last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/klr_key_mem.sv */
`default_nettype none

module klr_key_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  klr_pkg::t_mem_wr             i_wr,
    input  logic                         i_rd_en,
    input  logic [klr_pkg::KEY_AW-1:0]   i_rd_addr,
    output klr_pkg::t_entry              o_rd_data,
    output logic                         o_clr_busy
);
    import klr_pkg::*;

    t_entry            r_mem [KEY_COUNT];
    t_entry            r_rd_data;
    logic              r_clr_busy;
    logic [KEY_AW-1:0] r_clr_addr;
    t_mem_wr           n_wr;

    // The clearing pass owns the write port until every entry is zero.
    always_comb begin
        if (r_clr_busy) begin
            n_wr = '{en: 1'b1, addr: r_clr_addr, data: '0};
        end else begin
            n_wr = i_wr;
        end
    end

    // Clearing pass sequencer, one entry per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == KEY_AW'(KEY_COUNT - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Single write port, single registered read port; a read sees the old data.
    always_ff @(posedge i_clk) begin
        if (n_wr.en) begin
            r_mem[n_wr.addr] <= n_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

/* rtl/core/keyboard_layer_remapper.sv */
`default_nettype none

// Keyboard layer remapper. Each input transaction is one key event; it causes
// zero to five result transactions, the final one flagged by last, and all of
// them carry the held-key count after the event. The per-key state (down flag,
// added Shift, code sent) lives in a 768-entry memory that is read when an event
// is taken and written back when the event stage advances, with forwarding when
// the next event hits the same key. After reset a clearing pass zeroes that
// memory, during which no event is taken; configuration writes work at any time.
// An event is registered in the event stage; its results are loaded into the
// result buffer that drives the output when that stage advances. Events that
// cause at most one result are taken every cycle while the output is ready;
// otherwise the buffer drains one result per cycle while the output is ready.
// Configuration registers: long_hold_ms at byte address 0, max_hold_ms at 4.
module keyboard_layer_remapper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    klr_in_if.sink                        i_in,
    klr_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [klr_pkg::APB_AW-1:0]    paddr,
    input  logic [klr_pkg::APB_DW-1:0]    pwdata,
    output logic [klr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import klr_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]  r_long_hold;
    logic [CFG_W-1:0]  r_max_hold;

    // Scalar state.
    logic [1:0]        r_layer;
    logic [HELD_W-1:0] r_held;
    logic [TIME_W-1:0] r_home_t;
    logic              r_home_v;
    logic              r_kd_alt;
    logic              r_kd_lsh;
    logic              r_kd_rsh;

    // Event stage waiting for its memory entry.
    logic              r_s1_valid;
    logic [CODE_W-1:0] r_s1_code;
    logic [PS_W-1:0]   r_s1_ps;
    logic [TIME_W-1:0] r_s1_time;
    logic              r_fwd_v;
    t_entry            r_fwd_data;

    // Result buffer.
    t_result           r_buf [NRES];
    logic [NRES_W-1:0] r_cnt;

    // Next values from the event stage.
    t_result           n_res [NRES];
    logic [NRES_W-1:0] n_cnt;
    t_mem_wr           n_wr;
    logic [1:0]        n_layer;
    logic [HELD_W-1:0] n_held;
    logic [TIME_W-1:0] n_home_t;
    logic              n_home_v;

    t_entry            mem_rd;
    logic              clr_busy;
    logic              in_acc;
    logic              out_pop;
    logic              emit_free;
    logic              s1_adv;
    logic              rd_en;

    // APB port: writes in the access phase, reads decoded on the same bit.
    assign pready = 1'b1;
    always_comb begin
        if (paddr[2] == REG_MAX_HOLD) begin
            prdata = APB_DW'(r_max_hold);
        end else begin
            prdata = APB_DW'(r_long_hold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_hold <= LONG_HOLD_RST;
            r_max_hold  <= MAX_HOLD_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_MAX_HOLD) begin
                r_max_hold <= pwdata[CFG_W-1:0];
            end else begin
                r_long_hold <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Handshakes between input, event stage and result buffer.
    assign emit_free  = (r_cnt == '0) || ((r_cnt == NRES_W'(1)) && o_out.ready);
    assign s1_adv     = r_s1_valid && emit_free;
    assign i_in.ready = !clr_busy && (!r_s1_valid || s1_adv);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_pop    = o_out.valid && o_out.ready;
    assign rd_en      = in_acc && ({1'b0, i_in.key_code} < (CODE_W + 1)'(KEY_COUNT));

    klr_key_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (n_wr),
        .i_rd_en    (rd_en),
        .i_rd_addr  (i_in.key_code[KEY_AW-1:0]),
        .o_rd_data  (mem_rd),
        .o_clr_busy (clr_busy)
    );

    // Event stage: decode the event against its key entry and build the results.
    always_comb begin
        t_entry            ent;
        t_layer            lm;
        logic [CODE_W-1:0] mapped;
        logic [CODE_W-1:0] up;
        logic              added;
        logic              is_key;
        logic [TIME_W-1:0] hold;
        logic [NRES_W-1:0] idx;

        ent      = r_fwd_v ? r_fwd_data : mem_rd;
        lm       = layer_map(r_s1_code);
        mapped   = host_code(r_s1_code);
        up       = '0;
        added    = ent.added;
        is_key   = 1'b0;
        hold     = '0;
        idx      = '0;
        n_layer  = r_layer;
        n_held   = r_held;
        n_home_t = r_home_t;
        n_home_v = r_home_v;
        n_wr     = '{en: 1'b0, addr: r_s1_code[KEY_AW-1:0], data: '0};
        for (int k = 0; k < NRES; k++) begin
            n_res[k] = '0;
        end

        if (r_s1_ps == PS_PRESS || r_s1_ps == PS_RELEASE) begin
            if (r_s1_code == KEY_HOME) begin
                if (r_s1_ps == PS_PRESS) begin
                    n_home_t = r_s1_time;
                    n_home_v = 1'b1;
                end else begin
                    hold = r_home_v ? (r_s1_time - r_home_t) : '0;
                    if (hold > TIME_W'(r_max_hold)) begin
                        hold = '0;
                    end
                    n_home_t = '0;
                    n_home_v = 1'b0;
                    n_res[idx].action = (hold >= TIME_W'(r_long_hold)) ?
                                        ACT_HOME_LONG : ACT_HOME_SHORT;
                    idx = idx + 1'b1;
                end
            end else if (r_s1_code == KEY_BACK) begin
                if (r_s1_ps == PS_RELEASE) begin
                    n_res[idx].action = ACT_LEAVE;
                    idx = idx + 1'b1;
                end
            end else if (r_s1_code == KEY_VOL_DN || r_s1_code == KEY_VOL_UP ||
                         r_s1_code == KEY_PWR) begin
                if (r_s1_ps == PS_PRESS) begin
                    n_res[idx].action = ACT_REINJECT;
                    if (r_s1_code == KEY_VOL_DN) begin
                        n_res[idx].out_code = AKEY_VOL_DN;
                    end else if (r_s1_code == KEY_VOL_UP) begin
                        n_res[idx].out_code = AKEY_VOL_UP;
                    end else begin
                        n_res[idx].out_code = AKEY_PWR;
                    end
                    idx = idx + 1'b1;
                end
            end else if ({1'b0, r_s1_code} >= (CODE_W + 1)'(KEY_COUNT)) begin
                is_key = 1'b0;
            end else if (r_s1_code == KEY_SYM_A) begin
                n_layer[0] = (r_s1_ps == PS_PRESS);
            end else if (r_s1_code == KEY_SYM_B) begin
                n_layer[1] = (r_s1_ps == PS_PRESS);
            end else begin
                is_key = 1'b1;
            end
        end

        // Ordinary key: remap, track state, release stale modifiers on a press.
        if (is_key) begin
            if (r_layer != '0 && lm.hit) begin
                mapped = lm.code;
                if (r_s1_ps == PS_PRESS && lm.shift && !r_kd_lsh && !r_kd_rsh) begin
                    added = 1'b1;
                end
            end
            n_wr.en = s1_adv;
            if (r_s1_ps == PS_PRESS) begin
                if (!is_modifier(r_s1_code)) begin
                    if (!r_kd_alt) begin
                        n_res[idx].out_code = KEY_LALT;
                        idx = idx + 1'b1;
                    end
                    if (!r_kd_lsh) begin
                        n_res[idx].out_code = KEY_LSHIFT;
                        idx = idx + 1'b1;
                    end
                    if (!r_kd_rsh) begin
                        n_res[idx].out_code = KEY_RSHIFT;
                        idx = idx + 1'b1;
                    end
                    if (!ent.kd && r_held != '1) begin
                        n_held = r_held + 1'b1;
                    end
                end
                n_wr.data = '{kd: 1'b1, added: added, sent: mapped};
                if (added) begin
                    n_res[idx].out_code = KEY_LSHIFT;
                    n_res[idx].is_down  = 1'b1;
                    idx = idx + 1'b1;
                end
                n_res[idx].out_code = mapped;
                n_res[idx].is_down  = 1'b1;
                idx = idx + 1'b1;
            end else begin
                up = (ent.sent != '0) ? ent.sent : mapped;
                if (ent.kd && !is_modifier(r_s1_code) && r_held != '0) begin
                    n_held = r_held - 1'b1;
                end
                n_wr.data = '0;
                n_res[idx].out_code = up;
                idx = idx + 1'b1;
                if (ent.added) begin
                    n_res[idx].out_code = KEY_LSHIFT;
                    idx = idx + 1'b1;
                end
            end
        end

        // Every result carries the updated count; the final one is marked.
        for (int k = 0; k < NRES; k++) begin
            n_res[k].held_count = n_held;
            n_res[k].last       = (NRES_W'(k) == idx - 1'b1);
        end
        n_cnt = idx;
    end

    // Event stage register, memory forwarding and scalar state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_v    <= 1'b0;
            r_layer    <= '0;
            r_held     <= '0;
            r_home_t   <= '0;
            r_home_v   <= 1'b0;
            r_kd_alt   <= 1'b0;
            r_kd_lsh   <= 1'b0;
            r_kd_rsh   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd_v    <= n_wr.en && (n_wr.addr == i_in.key_code[KEY_AW-1:0]);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_layer  <= n_layer;
                r_held   <= n_held;
                r_home_t <= n_home_t;
                r_home_v <= n_home_v;
            end
            if (n_wr.en) begin
                if (n_wr.addr == KEY_FREE_ALT[KEY_AW-1:0]) begin
                    r_kd_alt <= n_wr.data.kd;
                end
                if (n_wr.addr == KEY_LSHIFT[KEY_AW-1:0]) begin
                    r_kd_lsh <= n_wr.data.kd;
                end
                if (n_wr.addr == KEY_RSHIFT[KEY_AW-1:0]) begin
                    r_kd_rsh <= n_wr.data.kd;
                end
            end
        end
    end

    // Event payload and forwarded entry.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_code  <= i_in.key_code;
            r_s1_ps    <= i_in.press_state;
            r_s1_time  <= i_in.time_ms;
            r_fwd_data <= n_wr.data;
        end
    end

    // Result buffer: loaded whole, drained from the head one per cycle while the output is ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (s1_adv && n_cnt != '0) begin
            r_cnt <= n_cnt;
        end else if (out_pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && n_cnt != '0) begin
            for (int k = 0; k < NRES; k++) begin
                r_buf[k] <= n_res[k];
            end
        end else if (out_pop) begin
            for (int k = 0; k < NRES - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
        end
    end

    // Output channel.
    assign o_out.valid      = (r_cnt != '0);
    assign o_out.action     = r_buf[0].action;
    assign o_out.out_code   = r_buf[0].out_code;
    assign o_out.is_down    = r_buf[0].is_down;
    assign o_out.held_count = r_buf[0].held_count;
    assign o_out.last       = r_buf[0].last;

endmodule

`default_nettype wire

/* tb/sv/keyboard_layer_remapper_tb.sv */
`timescale 1ns / 100ps

module keyboard_layer_remapper_tb;
    import klr_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;

    // Symbol layer lookup: host code of the glyph and whether it needs Shift.
    typedef struct packed {
        logic              shift;
        logic [CODE_W-1:0] host;
    } t_glyph;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    klr_in_if  in_ch ();
    klr_out_if out_ch ();

    keyboard_layer_remapper DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted key state and configuration.
    bit                key_is_down [KEY_COUNT];
    bit                shift_added [KEY_COUNT];
    bit [CODE_W-1:0]   code_sent [KEY_COUNT];
    bit [1:0]          sym_layer;
    bit [HELD_W-1:0]   held_keys;
    bit [TIME_W-1:0]   home_t;
    bit                home_armed;
    bit [CFG_W-1:0]    long_hold_cfg = LONG_HOLD_RST;
    bit [CFG_W-1:0]    max_hold_cfg  = MAX_HOLD_RST;

    // Host events still to come out of the block, oldest first.
    t_result           remapped_q [$];
    t_result           head_result;
    int                mismatches;

    // Sender and receiver pacing.
    int                burst_left;
    int                rx_mode;
    int                rx_left;
    int                rx_phase;
    int                idle_cycles;
    bit [TIME_W-1:0]   now_ms;
    logic [CODE_W-1:0] held_list [$];

    // The clock runs freely from time zero.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic t_result mk_result(input logic [ACT_W-1:0] act,
                                          input logic [CODE_W-1:0] c, input logic down);
        t_result r;
        r = '0;
        r.action = act;
        r.out_code = c;
        r.is_down = down;
        return r;
    endfunction

    function automatic bit is_mod_key(input logic [CODE_W-1:0] code);
        case (code)
            KEY_LCTRL, KEY_LSHIFT, KEY_RSHIFT, KEY_LALT, KEY_RCTRL, KEY_FREE_ALT,
            KEY_LMETA, KEY_RMETA, KEY_FN_A, KEY_FN_B, KEY_SYM_A, KEY_SYM_B: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Glyph of a letter key under the symbol layer, looked up as a HID usage
    // and then turned into a host code. A host code of zero means no glyph.
    function automatic t_glyph sym_glyph(input logic [CODE_W-1:0] code);
        t_glyph g;
        logic [7:0] usage;
        g.shift = 1'b0;
        usage = 8'h00;
        case (code)
            10'd16: usage = 8'h27;
            10'd17: usage = 8'h1e;
            10'd18: usage = 8'h1f;
            10'd19: usage = 8'h20;
            10'd20: begin g.shift = 1'b1; usage = 8'h26; end
            10'd21: begin g.shift = 1'b1; usage = 8'h27; end
            10'd22: begin g.shift = 1'b1; usage = 8'h2d; end
            10'd23: usage = 8'h2d;
            10'd24: usage = 8'h38;
            10'd25: begin g.shift = 1'b1; usage = 8'h33; end
            10'd30: begin g.shift = 1'b1; usage = 8'h1f; end
            10'd31: usage = 8'h21;
            10'd32: usage = 8'h22;
            10'd33: usage = 8'h23;
            10'd34: begin g.shift = 1'b1; usage = 8'h25; end
            10'd35: begin g.shift = 1'b1; usage = 8'h20; end
            10'd36: begin g.shift = 1'b1; usage = 8'h2e; end
            10'd37: begin g.shift = 1'b1; usage = 8'h34; end
            10'd38: usage = 8'h34;
            10'd44: begin g.shift = 1'b1; usage = 8'h1e; end
            10'd45: usage = 8'h24;
            10'd46: usage = 8'h25;
            10'd47: usage = 8'h26;
            10'd48: usage = 8'h37;
            10'd49: usage = 8'h36;
            10'd50: begin g.shift = 1'b1; usage = 8'h38; end
            default: usage = 8'h00;
        endcase
        if (usage >= 8'h1e && usage <= 8'h27) begin
            g.host = usage - 8'h1e + 10'd2;
        end else begin
            case (usage)
                8'h2d: g.host = 10'd12;
                8'h2e: g.host = 10'd13;
                8'h33: g.host = 10'd39;
                8'h34: g.host = 10'd40;
                8'h36: g.host = 10'd51;
                8'h37: g.host = 10'd52;
                8'h38: g.host = 10'd53;
                default: g.host = '0;
            endcase
        end
        return g;
    endfunction

    // Works out the host events of one key event and queues them.
    task automatic remap_event(input logic [CODE_W-1:0] code, input logic [PS_W-1:0] ps,
                               input logic [TIME_W-1:0] t_ms);
        t_result           burst [$];
        logic [TIME_W-1:0] hold;
        logic [CODE_W-1:0] mapped;
        logic [CODE_W-1:0] up_code;
        t_glyph            g;
        if (ps == PS_PRESS || ps == PS_RELEASE) begin
            if (code == KEY_HOME) begin
                if (ps == PS_PRESS) begin
                    home_t = t_ms;
                    home_armed = 1'b1;
                end else begin
                    // A release without a press, or an overlong hold, counts as zero.
                    hold = home_armed ? t_ms - home_t : '0;
                    home_armed = 1'b0;
                    home_t = '0;
                    if (hold > max_hold_cfg) hold = '0;
                    burst.push_back(mk_result(hold >= long_hold_cfg ? ACT_HOME_LONG
                                                                    : ACT_HOME_SHORT, '0, 1'b0));
                end
            end else if (code == KEY_BACK) begin
                if (ps == PS_RELEASE) burst.push_back(mk_result(ACT_LEAVE, '0, 1'b0));
            end else if (code == KEY_VOL_DN || code == KEY_VOL_UP || code == KEY_PWR) begin
                if (ps == PS_PRESS) begin
                    burst.push_back(mk_result(ACT_REINJECT,
                        code == KEY_VOL_DN ? AKEY_VOL_DN :
                        (code == KEY_VOL_UP ? AKEY_VOL_UP : AKEY_PWR), 1'b0));
                end
            end else if (code >= KEY_COUNT) begin
                // Codes beyond the key table are dropped.
            end else if (code == KEY_SYM_A || code == KEY_SYM_B) begin
                sym_layer[code == KEY_SYM_B] = (ps == PS_PRESS);
            end else begin
                // Rename free Alt and Fn, then apply the symbol layer.
                mapped = (code == KEY_FREE_ALT) ? KEY_LALT :
                         ((code == KEY_FN_A || code == KEY_FN_B) ? KEY_LCTRL : code);
                if (sym_layer != 0) begin
                    g = sym_glyph(code);
                    if (g.host != 0) begin
                        mapped = g.host;
                        if (ps == PS_PRESS && g.shift && !key_is_down[KEY_LSHIFT]
                            && !key_is_down[KEY_RSHIFT]) shift_added[code] = 1'b1;
                    end
                end
                if (ps == PS_PRESS) begin
                    // A plain key first releases stale Alt and Shift in the host.
                    if (!is_mod_key(code)) begin
                        if (!key_is_down[KEY_FREE_ALT])
                            burst.push_back(mk_result(ACT_HOST, KEY_LALT, 1'b0));
                        if (!key_is_down[KEY_LSHIFT])
                            burst.push_back(mk_result(ACT_HOST, KEY_LSHIFT, 1'b0));
                        if (!key_is_down[KEY_RSHIFT])
                            burst.push_back(mk_result(ACT_HOST, KEY_RSHIFT, 1'b0));
                        if (!key_is_down[code] && held_keys < 10'd1023) held_keys++;
                    end
                    key_is_down[code] = 1'b1;
                    code_sent[code] = mapped;
                    if (shift_added[code]) burst.push_back(mk_result(ACT_HOST, KEY_LSHIFT, 1'b1));
                    burst.push_back(mk_result(ACT_HOST, mapped, 1'b1));
                end else begin
                    // The release matches the code sent at press time when there is one.
                    up_code = (code_sent[code] != 0) ? code_sent[code] : mapped;
                    if (key_is_down[code] && !is_mod_key(code) && held_keys > 0) held_keys--;
                    key_is_down[code] = 1'b0;
                    code_sent[code] = '0;
                    burst.push_back(mk_result(ACT_HOST, up_code, 1'b0));
                    if (shift_added[code]) begin
                        shift_added[code] = 1'b0;
                        burst.push_back(mk_result(ACT_HOST, KEY_LSHIFT, 1'b0));
                    end
                end
            end
        end
        foreach (burst[i]) begin
            burst[i].held_count = held_keys;
            burst[i].last = (i == burst.size() - 1);
            remapped_q.push_back(burst[i]);
        end
    endtask

    // Sends one key event in bursts with random gaps; entered and left at a falling edge.
    task automatic post_key(input logic [CODE_W-1:0] code, input logic [PS_W-1:0] ps,
                            input logic [TIME_W-1:0] t_ms);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid <= 1'b1;
        in_ch.key_code <= code;
        in_ch.press_state <= ps;
        in_ch.time_ms <= t_ms;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        remap_event(code, ps, t_ms);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Holds off the sender until every predicted event has come out.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (remapped_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes one register over the APB port and reads it back.
    task automatic set_reg(input logic idx, input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom()), value};
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (idx == REG_LONG_HOLD) long_hold_cfg = value;
        else max_hold_cfg = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[CFG_W-1:0] !== value)
            flag_mismatch($sformatf("register %0d reads %0d, wrote %0d", idx, rd, value));
    endtask

    function automatic logic [CODE_W-1:0] pick_key();
        logic [CODE_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = 10'($urandom_range(16, 50));
            4: begin
                case ($urandom_range(0, 8))
                    0: k = KEY_LSHIFT;
                    1: k = KEY_RSHIFT;
                    2: k = KEY_FREE_ALT;
                    3: k = KEY_FN_A;
                    4: k = KEY_FN_B;
                    5: k = KEY_LCTRL;
                    6: k = KEY_LMETA;
                    7: k = KEY_LALT;
                    default: k = KEY_RCTRL;
                endcase
            end
            5: begin
                case ($urandom_range(0, 4))
                    0: k = KEY_HOME;
                    1: k = KEY_BACK;
                    2: k = KEY_VOL_DN;
                    3: k = KEY_VOL_UP;
                    default: k = KEY_PWR;
                endcase
            end
            6: k = $urandom_range(0, 1) ? KEY_SYM_A : KEY_SYM_B;
            7: k = 10'($urandom_range(0, KEY_COUNT - 1));
            default: k = 10'($urandom_range(0, 1023));
        endcase
        return k;
    endfunction

    // One random event: mostly press and release pairs, some noise.
    task automatic random_event(output int counted);
        logic [CODE_W-1:0] code;
        logic [PS_W-1:0]   ps;
        logic [TIME_W-1:0] t_ms;
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) now_ms = $urandom();
        else now_ms += $urandom_range(0, 1200);
        t_ms = now_ms;
        if (r < 12) begin
            code = $urandom_range(0, 1) ? pick_key() : 10'($urandom_range(0, 1023));
            ps = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) t_ms = $urandom();
        end else if (held_list.size() != 0 && (r < 55 || held_list.size() >= 6)) begin
            idx = $urandom_range(0, held_list.size() - 1);
            code = held_list[idx];
            held_list.delete(idx);
            ps = PS_RELEASE;
        end else begin
            code = pick_key();
            ps = PS_PRESS;
            held_list.push_back(code);
        end
        post_key(code, ps, t_ms);
        counted = ((ps == PS_PRESS || ps == PS_RELEASE) && code < KEY_COUNT) ? 1 : 0;
    endtask

    // Special keys, field extremes and the symbol layer, at reset settings.
    task automatic test_directed_keys();
        post_key(KEY_HOME, PS_RELEASE, 32'd0);
        post_key(KEY_HOME, PS_PRESS, 32'd1000);
        post_key(KEY_HOME, PS_RELEASE, 32'd1700);
        post_key(KEY_HOME, PS_PRESS, 32'hFFFF_FE00);
        post_key(KEY_HOME, PS_RELEASE, 32'h0000_00C0);
        post_key(KEY_HOME, PS_PRESS, 32'd6000);
        post_key(KEY_HOME, PS_RELEASE, 32'd5000);
        post_key(KEY_BACK, PS_PRESS, 32'd6100);
        post_key(KEY_BACK, PS_RELEASE, 32'hFFFF_FFFF);
        post_key(KEY_VOL_DN, PS_PRESS, 32'd6200);
        post_key(KEY_VOL_UP, PS_PRESS, 32'd6300);
        post_key(KEY_PWR, PS_PRESS, 32'd6400);
        post_key(KEY_PWR, PS_RELEASE, 32'd6500);
        post_key(10'd1023, PS_PRESS, 32'd0);
        post_key(10'd30, 2'd3, 32'd6600);
        post_key(10'd0, PS_PRESS, 32'd6700);
        post_key(10'd0, PS_RELEASE, 32'd6800);
        post_key(KEY_FREE_ALT, PS_PRESS, 32'd6900);
        post_key(10'd16, PS_PRESS, 32'd7000);
        post_key(KEY_FREE_ALT, PS_RELEASE, 32'd7100);
        // Symbol layer with an added Shift, and a release that was never pressed.
        post_key(KEY_SYM_A, PS_PRESS, 32'd7200);
        post_key(10'd20, PS_PRESS, 32'd7300);
        post_key(10'd20, PS_RELEASE, 32'd7400);
        post_key(10'd17, PS_RELEASE, 32'd7500);
        post_key(KEY_SYM_A, PS_RELEASE, 32'd7600);
        post_key(10'd16, PS_RELEASE, 32'd7700);
        post_key(KEY_FN_B, PS_PRESS, 32'd7800);
        post_key(KEY_FN_B, PS_RELEASE, 32'd7900);
        drain_results();
    endtask

    // Home hold thresholds at the extremes of both registers.
    task automatic test_hold_extremes();
        set_reg(REG_LONG_HOLD, 16'd0);
        set_reg(REG_MAX_HOLD, 16'd0);
        post_key(KEY_HOME, PS_RELEASE, 32'd100);
        post_key(KEY_HOME, PS_PRESS, 32'd100);
        post_key(KEY_HOME, PS_RELEASE, 32'd150);
        drain_results();
        set_reg(REG_LONG_HOLD, 16'hFFFF);
        set_reg(REG_MAX_HOLD, 16'hFFFF);
        post_key(KEY_HOME, PS_PRESS, 32'd0);
        post_key(KEY_HOME, PS_RELEASE, 32'd65535);
        drain_results();
    endtask

    // Random typing over several register settings, with one full pause.
    task automatic test_random_typing();
        int phase;
        int taken;
        int step;
        bit paused;
        now_ms = 32'd10000;
        paused = 1'b0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    set_reg(REG_LONG_HOLD, LONG_HOLD_RST);
                    set_reg(REG_MAX_HOLD, MAX_HOLD_RST);
                end
                1: begin
                    set_reg(REG_LONG_HOLD, 16'($urandom_range(0, 1500)));
                    set_reg(REG_MAX_HOLD, 16'($urandom_range(0, 3000)));
                end
                2: begin
                    set_reg(REG_LONG_HOLD, 16'($urandom()));
                    set_reg(REG_MAX_HOLD, 16'($urandom()));
                end
                default: begin
                    set_reg(REG_LONG_HOLD, 16'($urandom_range(0, 1200)));
                    set_reg(REG_MAX_HOLD, 16'($urandom_range(500, 65535)));
                end
            endcase
            taken = 0;
            while (taken < 30) begin
                random_event(step);
                taken += step;
                if (phase == 1 && taken >= 15 && !paused) begin
                    paused = 1'b1;
                    drain_results();
                end
            end
            drain_results();
        end
    endtask

    // The receiver stalls on its own pattern, drawn anew at random.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 120);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 9) < 6);
            2: out_ch.ready <= (rx_phase % 4 == 0);
            default: out_ch.ready <= (rx_phase % 13 >= 9);
        endcase
    end

    // Each result transaction is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (remapped_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result action %0d code %0d down %0d",
                                        out_ch.action, out_ch.out_code, out_ch.is_down));
            end else begin
                head_result = remapped_q.pop_front();
                if (out_ch.action !== head_result.action)
                    flag_mismatch($sformatf("action %0d, expected %0d",
                                            out_ch.action, head_result.action));
                if (out_ch.out_code !== head_result.out_code)
                    flag_mismatch($sformatf("out_code %0d, expected %0d",
                                            out_ch.out_code, head_result.out_code));
                if (out_ch.is_down !== head_result.is_down)
                    flag_mismatch($sformatf("is_down %0d, expected %0d",
                                            out_ch.is_down, head_result.is_down));
                if (out_ch.held_count !== head_result.held_count)
                    flag_mismatch($sformatf("held_count %0d, expected %0d",
                                            out_ch.held_count, head_result.held_count));
                if (out_ch.last !== head_result.last)
                    flag_mismatch($sformatf("last %0d, expected %0d",
                                            out_ch.last, head_result.last));
            end
        end
    end

    // The run ends when no transaction moves for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Reset, then the tests in turn.
    initial begin
        in_ch.valid = 1'b0;
        in_ch.key_code = '0;
        in_ch.press_state = '0;
        in_ch.time_ms = '0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        mismatches = 0;
        burst_left = 0;
        rx_left = 0;
        rx_phase = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_keys();
        test_hold_extremes();
        test_random_typing();
        drain_results();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
